FILE: design/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the integer literal scanner.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int LIT_W          = 64;  // width of the reported value
    localparam int CHAR_W         = 8;
    localparam int VALUE_BITS_DEF = 64;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;  // 'f'
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;  // 'F'
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;  // 'x'
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;  // 'X'
    localparam logic [CHAR_W-1:0] CH_LO_B  = 8'h62;  // 'b'
    localparam logic [CHAR_W-1:0] CH_UP_B  = 8'h42;  // 'B'

    typedef enum logic [1:0] {
        KIND_DEC = 2'd0,
        KIND_HEX = 2'd1,
        KIND_BIN = 2'd2,
        KIND_OCT = 2'd3
    } t_base;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ZERO   = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    typedef struct packed {
        logic digit_err;
        logic overflow;
    } t_step_flags;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] value;
    } t_digit;

    function automatic t_digit decode_digit(input logic [CHAR_W-1:0] c);
        t_digit d;
        d.is_digit = 1'b1;
        d.value    = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.value = c[3:0];
        end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
            d.value = c[3:0] + 4'd9;
        end else begin
            d.is_digit = 1'b0;
        end
        return d;
    endfunction

endpackage

FILE: design/ils_if.sv
// ----------------------------------------------------------------------------
// ils_char_if / ils_lit_if
// Valid/ready channels: characters in, scanned literals out.
// ----------------------------------------------------------------------------
interface ils_char_if;
    logic       valid;
    logic       ready;
    logic       first_char;
    logic [7:0] char_code;

    modport source (output valid, output first_char, output char_code, input ready);
    modport sink   (input valid, input first_char, input char_code, output ready);
endinterface

interface ils_lit_if;
    logic        valid;
    logic        ready;
    logic [63:0] literal_value;
    logic [1:0]  base_kind;
    logic        digit_error;
    logic        overflow_error;

    modport source (output valid, output literal_value, output base_kind,
                    output digit_error, output overflow_error, input ready);
    modport sink   (input valid, input literal_value, input base_kind,
                    input digit_error, input overflow_error, output ready);
endinterface

FILE: design/integer_literal_scanner.sv
// ----------------------------------------------------------------------------
// integer_literal_scanner
// Scans integer literals one character per item, with 0x / 0b / 0 prefixes,
// and emits value, base kind and error flags when a non-digit ends a literal.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                           | result
//  i_char   | in  | first_char, char_code                             | 0 or 1
//  o_lit    | out | literal_value, base_kind, digit_error, overflow_error | -
//
// One character per cycle unless a held result stalls the input; the ending character
// passes the input register, then the result register, before its result is on o_lit.
// The accumulate step (shift/add by the radix plus carry check) sits between
// the input register and the state/result registers.
// Reset clears the scan state, the input valid and the result valid.
// A result held on o_lit stalls the input register, which then stalls i_char.
module integer_literal_scanner #(
    parameter int VALUE_BITS = ils_pkg::VALUE_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ils_char_if.sink i_char,
    ils_lit_if.source o_lit
);
    import ils_pkg::*;

    // input register
    logic                r_in_valid;
    logic                r_first;
    logic [CHAR_W-1:0]   r_char;

    // scan state
    t_phase              r_phase, n_phase;
    t_base               r_base, n_base;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                r_derr, n_derr;
    logic                r_ovf, n_ovf;

    // result register
    logic                r_out_valid;
    logic [LIT_W-1:0]    r_out_value;
    t_base               r_out_base;
    logic                r_out_derr;
    logic                r_out_ovf;

    logic                w_fire;
    logic                w_eval;
    logic                w_emit;
    t_base               w_base;
    logic [VALUE_BITS-1:0] w_acc;
    logic                w_derr;
    logic                w_ovf;
    t_digit              w_dig;
    logic [VALUE_BITS-1:0] w_step_acc;
    t_step_flags         w_step_flags;

    assign w_fire       = r_in_valid && (!r_out_valid || o_lit.ready);
    assign i_char.ready = !r_in_valid || w_fire;
    assign w_dig        = decode_digit(r_char);

    ils_radix_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .i_acc   (w_acc),
        .i_base  (w_base),
        .i_digit (w_dig.value),
        .o_acc   (w_step_acc),
        .o_flags (w_step_flags)
    );

    // next state
    always_comb begin
        n_phase = r_phase;
        n_base  = r_base;
        n_acc   = r_acc;
        n_derr  = r_derr;
        n_ovf   = r_ovf;
        w_eval  = 1'b0;
        w_base  = r_base;
        w_acc   = r_acc;
        w_derr  = r_derr;
        w_ovf   = r_ovf;
        if (w_fire) begin
            if (r_first) begin
                w_base = KIND_DEC;
                w_acc  = '0;
                w_derr = 1'b0;
                w_ovf  = 1'b0;
                if (r_char == CH_ZERO) begin
                    n_phase = PH_ZERO;
                end else begin
                    n_phase = PH_DIGITS;
                    w_eval  = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_ZERO: begin
                        n_phase = PH_DIGITS;
                        if (r_char == CH_LO_X || r_char == CH_UP_X) begin
                            w_base = KIND_HEX;
                        end else if (r_char == CH_LO_B || r_char == CH_UP_B) begin
                            w_base = KIND_BIN;
                        end else begin
                            if (r_char >= CH_ZERO && r_char <= CH_NINE) begin
                                w_base = KIND_OCT;
                            end
                            w_eval = 1'b1;
                        end
                    end
                    PH_DIGITS: w_eval = 1'b1;
                    default: ;
                endcase
            end
            n_base = w_base;
            n_acc  = w_acc;
            n_derr = w_derr;
            n_ovf  = w_ovf;
            if (w_eval) begin
                if (!w_dig.is_digit) begin
                    n_phase = PH_IDLE;
                end else if (!w_ovf) begin
                    n_acc  = w_step_acc;
                    n_derr = w_derr | w_step_flags.digit_err;
                    n_ovf  = w_step_flags.overflow;
                end
            end
        end
    end

    // result strobe
    always_comb begin
        w_emit = w_eval && !w_dig.is_digit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_base      <= KIND_DEC;
            r_acc       <= '0;
            r_derr      <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_lit.ready) begin
                r_out_valid <= 1'b0;
            end
            r_phase <= n_phase;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_derr  <= n_derr;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_first <= i_char.first_char;
            r_char  <= i_char.char_code;
        end
        if (w_emit) begin
            r_out_value <= w_ovf ? '0 : LIT_W'(w_acc);
            r_out_base  <= w_base;
            r_out_derr  <= w_derr;
            r_out_ovf   <= w_ovf;
        end
    end

    assign o_lit.valid          = r_out_valid;
    assign o_lit.literal_value  = r_out_value;
    assign o_lit.base_kind      = r_out_base;
    assign o_lit.digit_error    = r_out_derr;
    assign o_lit.overflow_error = r_out_ovf;

    // after a leading zero nothing has been accumulated yet
    a_zero_phase_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ZERO) |-> (r_base == KIND_DEC && r_acc == '0 && !r_ovf))
        else $error("leading-zero phase with nonempty state");

    a_ovf_clears_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_acc == '0))
        else $error("accumulator not cleared after overflow");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || o_lit.ready))
        else $error("pending result overwritten");

    a_ovf_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> (r_out_value == '0))
        else $error("overflowed literal reports nonzero value");

endmodule

FILE: design/ils_radix_step.sv
// ----------------------------------------------------------------------------
// ils_radix_step
// One accumulate step: acc * radix + digit, with range and overflow check.
// ----------------------------------------------------------------------------
module ils_radix_step #(
    parameter int VALUE_BITS = ils_pkg::VALUE_BITS_DEF
) (
    input  logic [VALUE_BITS-1:0] i_acc,
    input  ils_pkg::t_base        i_base,
    input  logic [3:0]            i_digit,
    output logic [VALUE_BITS-1:0] o_acc,
    output ils_pkg::t_step_flags  o_flags
);
    import ils_pkg::*;

    localparam int EXT_W = VALUE_BITS + 5;

    logic [EXT_W-1:0] w_acc_ext;
    logic [EXT_W-1:0] w_prod;
    logic [EXT_W-1:0] w_sum;
    logic [3:0]       w_digit;
    logic             w_bad;

    assign w_acc_ext = EXT_W'(i_acc);

    // radix is a constant per base: shifts only, plus an add for decimal
    always_comb begin
        unique case (i_base)
            KIND_HEX: begin
                w_prod = w_acc_ext << 4;
                w_bad  = 1'b0;
            end
            KIND_OCT: begin
                w_prod = w_acc_ext << 3;
                w_bad  = (i_digit > 4'd7);
            end
            KIND_BIN: begin
                w_prod = w_acc_ext << 1;
                w_bad  = (i_digit > 4'd1);
            end
            default: begin
                w_prod = (w_acc_ext << 3) + (w_acc_ext << 1);
                w_bad  = (i_digit > 4'd9);
            end
        endcase
    end

    assign w_digit = w_bad ? 4'd0 : i_digit;
    assign w_sum   = w_prod + EXT_W'(w_digit);

    assign o_flags.digit_err = w_bad;
    assign o_flags.overflow  = |w_sum[EXT_W-1:VALUE_BITS];
    assign o_acc             = o_flags.overflow ? '0 : w_sum[VALUE_BITS-1:0];

endmodule

FILE: dv/tb_integer_literal_scanner.sv
// ----------------------------------------------------------------------------
// tb_integer_literal_scanner
// Streams character items into the scanner: a short directed list of edge
// cases, then random literals in every base with random content, values at
// and past the 64-bit limit, cut-off literals and stray characters. A
// scoreboard models the scan state and checks each literal item in order.
// Runs through phases of sender idling and receiver stalling, with one long
// receiver hold-off that backs the scanner up.
// ----------------------------------------------------------------------------
module tb_integer_literal_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    import ils_pkg::*;

    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [63:0] value;
        t_base       kind;
        logic        digit_err;
        logic        overflow;
    } t_literal;

    class literal_scoreboard;
        localparam logic [4:0] NO_DIGIT = 5'd16;

        t_phase      phase;
        t_base       base;
        logic [63:0] acc;
        logic        digit_err_seen;
        logic        overflow_seen;
        t_literal    expected_q[$];
        int          errors;

        function void clear();
            phase          = PH_IDLE;
            base           = KIND_DEC;
            acc            = '0;
            digit_err_seen = 1'b0;
            overflow_seen  = 1'b0;
            errors         = 0;
            expected_q.delete();
        endfunction

        function logic [4:0] char_digit(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
            if (c >= CH_LO_A && c <= CH_LO_F) return 5'(c - CH_LO_A + 8'd10);
            if (c >= CH_UP_A && c <= CH_UP_F) return 5'(c - CH_UP_A + 8'd10);
            return NO_DIGIT;
        endfunction

        function logic [63:0] base_radix(t_base b);
            case (b)
                KIND_HEX: return 64'd16;
                KIND_BIN: return 64'd2;
                KIND_OCT: return 64'd8;
                default:  return 64'd10;
            endcase
        endfunction

        // returns 0 when the scanner ignores the character
        function bit note_char(logic first, logic [7:0] c);
            logic [4:0]  d;
            logic [63:0] radix;
            t_literal    lit;
            if (first) begin
                acc            = '0;
                digit_err_seen = 1'b0;
                overflow_seen  = 1'b0;
                base           = KIND_DEC;
                if (c == CH_ZERO) begin
                    phase = PH_ZERO;
                    return 1'b1;
                end
                phase = PH_DIGITS;
            end else if (phase == PH_ZERO) begin
                phase = PH_DIGITS;
                if (c == CH_LO_X || c == CH_UP_X) begin
                    base = KIND_HEX;
                    return 1'b1;
                end
                if (c == CH_LO_B || c == CH_UP_B) begin
                    base = KIND_BIN;
                    return 1'b1;
                end
                if (c >= CH_ZERO && c <= CH_NINE) base = KIND_OCT;
            end else if (phase != PH_DIGITS) begin
                return 1'b0;
            end
            d = char_digit(c);
            if (d == NO_DIGIT) begin
                lit.value     = overflow_seen ? '0 : acc;
                lit.kind      = base;
                lit.digit_err = digit_err_seen;
                lit.overflow  = overflow_seen;
                expected_q.push_back(lit);
                phase = PH_IDLE;
                return 1'b1;
            end
            // after overflow, digits are swallowed with no range check
            if (overflow_seen) return 1'b1;
            radix = base_radix(base);
            if (64'(d) >= radix) begin
                digit_err_seen = 1'b1;
                d              = '0;
            end
            if (acc > ({64{1'b1}} - 64'(d)) / radix) begin
                overflow_seen = 1'b1;
                acc           = '0;
                return 1'b1;
            end
            acc = acc * radix + 64'(d);
            return 1'b1;
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_literal(logic [63:0] value, logic [1:0] kind,
                                    logic digit_err, logic overflow);
            t_literal lit;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: literal expected none, actual value %0h kind %0d",
                         $time, value, kind);
                return;
            end
            lit = expected_q.pop_front();
            check_field("literal_value", lit.value, value);
            check_field("base_kind", 64'(lit.kind), 64'(kind));
            check_field("digit_error", 64'(lit.digit_err), 64'(digit_err));
            check_field("overflow_error", 64'(lit.overflow), 64'(overflow));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ils_char_if char_ch();
    ils_lit_if  lit_ch();

    integer_literal_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_lit   (lit_ch)
    );

    literal_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int items_taken    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_char(input logic first, input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            char_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_ch.valid      <= 1'b1;
        char_ch.first_char <= first;
        char_ch.char_code  <= c;
        do @(posedge i_clk); while (char_ch.ready !== 1'b1);
        if (sb.note_char(first, c)) items_taken++;
    endtask

    task automatic send_text(input string s, input logic starts);
        int i;
        for (i = 0; i < s.len(); i++) send_char(starts && i == 0, s[i]);
    endtask

    function automatic logic [7:0] digit_char(int unsigned v);
        if (v < 10) return 8'(CH_ZERO + v);
        return 8'(($urandom_range(1) ? CH_UP_A : CH_LO_A) + v - 10);
    endfunction

    function automatic logic [7:0] pick_ender();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (sb.char_digit(c) != literal_scoreboard::NO_DIGIT);
        return c;
    endfunction

    task automatic gen_literal();
        int     form;
        int     n;
        int     i;
        int     r;
        logic   err_mix;
        string  s;
        form    = $urandom_range(99);
        err_mix = ($urandom_range(9) == 0);
        n       = $urandom_range(1, 6);
        r       = 16;
        if (form < 25) begin
            send_char(1'b1, digit_char($urandom_range(1, 9)));
            r = 10;
            n = n - 1;
        end else if (form < 45) begin
            if ($urandom_range(1)) s = "0x";
            else s = "0X";
            send_text(s, 1'b1);
        end else if (form < 60) begin
            if ($urandom_range(1)) s = "0b";
            else s = "0B";
            send_text(s, 1'b1);
            r = 2;
            n = $urandom_range(1, 12);
        end else if (form < 75) begin
            send_char(1'b1, CH_ZERO);
            r = 8;
        end else if (form < 80) begin
            send_char(1'b1, CH_ZERO);
            n = 0;
        end else if (form < 85) begin
            send_text("0x", 1'b1);
            n = 0;
        end else if (form < 90) begin
            send_char(1'b1, 8'($urandom_range(255)));
            n = 0;
        end else begin
            // largest 64-bit value in each base; any further digit overflows
            case ($urandom_range(3))
                0: s = "18446744073709551615";
                1: begin
                    s = "0x";
                    for (i = 0; i < 16; i++) begin
                        if ($urandom_range(1)) s = {s, "F"};
                        else s = {s, "f"};
                    end
                end
                2: begin
                    s = "0b";
                    for (i = 0; i < 64; i++) s = {s, "1"};
                end
                default: s = "01777777777777777777777";
            endcase
            send_text(s, 1'b1);
            n       = $urandom_range(1) ? $urandom_range(1, 3) : 0;
            err_mix = 1'b1;
        end
        for (i = 0; i < n; i++)
            send_char(1'b0, digit_char(err_mix ? $urandom_range(15) : $urandom_range(r - 1)));
        // a few literals are cut off by the next first character
        if ($urandom_range(19) != 0) begin
            send_char(1'b0, pick_ender());
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) send_char(1'b0, 8'($urandom_range(255)));
            end
        end
    endtask

    // receiver: checks literal items, stalls at random, long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        lit_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (lit_ch.valid === 1'b1 && lit_ch.ready === 1'b1)
                sb.check_literal(lit_ch.literal_value, lit_ch.base_kind,
                                 lit_ch.digit_error, lit_ch.overflow_error);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                lit_ch.ready <= 1'b0;
            end else begin
                lit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int ph;
        int goal;
        bit hold_done;
        hold_done = 1'b0;
        sb.clear();
        i_rst_n            <= 1'b0;
        char_ch.valid      <= 1'b0;
        char_ch.first_char <= 1'b0;
        char_ch.char_code  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_char(1'b1, "+");          // literal ends on its first character
        send_char(1'b0, 8'h00);        // stray character while idle
        send_text("0x1F", 1'b1);
        send_char(1'b0, 8'hFF);
        send_text("0b102 ", 1'b1);     // digit out of range for binary
        send_text("09,", 1'b1);        // octal with a bad digit
        send_text("0x ", 1'b1);        // prefix with no digits
        send_text("A:", 1'b1);         // letter as first decimal digit
        send_text("12", 1'b1);         // abandoned by the next literal
        send_text("5)", 1'b1);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            goal = items_taken + RANDOM_ITEMS / 4;
            while (items_taken < goal) begin
                if (ph == 0 && !hold_done && items_taken >= goal - RANDOM_ITEMS / 8) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                gen_literal();
            end
        end
        char_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end

endmodule
